// ===== sv/urq_pkg.sv =====
// Shared types, constants and helper function of the ultrasonic range qualifier.
package urq_pkg;

    localparam int ECHO_W = 16;
    localparam int DIST_W = 15;
    localparam int CNT_W  = 16;

    localparam logic [ECHO_W-1:0] ECHO_MAX_RESET  = 16'd30000;
    localparam logic [DIST_W-1:0] CLOSE_TH_RESET  = 15'd480;
    localparam logic [DIST_W-1:0] CLEAR_TH_RESET  = 15'd640;
    localparam logic [3:0]        DEBOUNCE_RESET  = 4'd3;

    // Register indexes on the configuration port (byte address 4*index)
    localparam logic [1:0] REG_MAX_ECHO = 2'd0;
    localparam logic [1:0] REG_CLOSE_TH = 2'd1;
    localparam logic [1:0] REG_CLEAR_TH = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE = 2'd3;

    // floor(echo*8/29): reciprocal is floor(2^16*8/29), corrected by one step
    localparam logic [14:0] RECIP   = 15'd18078;
    localparam logic [4:0]  DIVISOR = 5'd29;

    localparam logic [2:0] MISS_LIMIT = 3'd5;
    localparam logic [2:0] MISS_SAT   = 3'd7;
    localparam logic [3:0] STREAK_SAT = 4'd15;
    localparam logic [1:0] WIN_LAST   = 2'd2;
    localparam logic [1:0] WIN_FULL   = 2'd3;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLOSE = 2'd1,
        EV_CLEAR = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [ECHO_W-1:0] max_echo_us;
        logic [DIST_W-1:0] close_threshold;
        logic [DIST_W-1:0] clear_threshold;
        logic [3:0]        debounce_count;
    } cfg_t;

    typedef struct packed {
        logic              reading_valid;
        logic [DIST_W-1:0] filtered_distance;
        event_kind_t       event_kind;
        logic [CNT_W-1:0]  timeout_count;
    } result_t;

    function automatic logic [DIST_W-1:0] median3(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b,
        input logic [DIST_W-1:0] c
    );
        logic ab;
        logic bc;
        logic ac;
        ab = (a > b);
        bc = (b > c);
        ac = (a > c);
        if (ab == bc)
            return b;
        else if (ab == ac)
            return c;
        else
            return a;
    endfunction

endpackage

// ===== sv/urq_cfg.sv =====
// APB-style configuration registers of the ultrasonic range qualifier.
module urq_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output urq_pkg::cfg_t       cfg
);
    import urq_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MAX_ECHO: cfg_next.max_echo_us     = pwdata[ECHO_W-1:0];
                REG_CLOSE_TH: cfg_next.close_threshold = pwdata[DIST_W-1:0];
                REG_CLEAR_TH: cfg_next.clear_threshold = pwdata[DIST_W-1:0];
                REG_DEBOUNCE: cfg_next.debounce_count  = pwdata[3:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAX_ECHO: prdata = {16'd0, cfg_reg.max_echo_us};
            REG_CLOSE_TH: prdata = {17'd0, cfg_reg.close_threshold};
            REG_CLEAR_TH: prdata = {17'd0, cfg_reg.clear_threshold};
            REG_DEBOUNCE: prdata = {28'd0, cfg_reg.debounce_count};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_echo_us     <= ECHO_MAX_RESET;
            cfg_reg.close_threshold <= CLOSE_TH_RESET;
            cfg_reg.clear_threshold <= CLEAR_TH_RESET;
            cfg_reg.debounce_count  <= DEBOUNCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/urq_dist.sv =====
// Echo time to distance in sixteenths of a cm: floor(echo*8/29) by reciprocal.
module urq_dist (
    input  logic [15:0] echo_time,
    output logic [14:0] distance
);
    import urq_pkg::*;

    logic [30:0] prod;
    logic [14:0] quot;
    logic [19:0] scaled;
    logic [19:0] back;
    logic [19:0] rem;

    // Estimate is exact or one low; the remainder check fixes the low case
    assign prod     = 31'(echo_time) * 31'(RECIP);
    assign quot     = prod[30:16];
    assign scaled   = {1'b0, echo_time, 3'b000};
    assign back     = 20'(quot) * 20'(DIVISOR);
    assign rem      = scaled - back;
    assign distance = (rem >= 20'(DIVISOR)) ? quot + 15'd1 : quot;

endmodule

// ===== sv/urq_track.sv =====
// Range tracking state: miss run, median window, close detector, timeout count.
module urq_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [15:0]          echo_time,
    input  logic [14:0]          distance,
    input  urq_pkg::cfg_t        cfg,
    output urq_pkg::result_t     res
);
    import urq_pkg::*;

    logic [DIST_W-1:0] window_reg [3];
    logic [DIST_W-1:0] window_next [3];
    logic [1:0]        pos_reg, pos_next;
    logic [1:0]        fill_reg, fill_next;
    logic [2:0]        miss_reg, miss_next;
    logic              valid_reg, valid_next;
    logic              close_reg, close_next;
    logic [3:0]        streak_reg, streak_next;
    logic [CNT_W-1:0]  timeouts_reg, timeouts_next;
    logic [DIST_W-1:0] last_reg, last_next;
    event_kind_t       ev;
    logic              good;
    logic              no_echo;
    logic [3:0]        streak_inc;

    assign no_echo = (echo_time == '0);
    assign good    = !no_echo && (echo_time <= cfg.max_echo_us);

    always_comb
    begin
        window_next   = window_reg;
        pos_next      = pos_reg;
        fill_next     = fill_reg;
        miss_next     = miss_reg;
        valid_next    = valid_reg;
        close_next    = close_reg;
        streak_next   = streak_reg;
        timeouts_next = timeouts_reg;
        last_next     = last_reg;
        ev            = EV_NONE;
        streak_inc    = (streak_reg < STREAK_SAT) ? streak_reg + 4'd1 : streak_reg;

        if (!good)
        begin
            if (no_echo && timeouts_reg != '1)
                timeouts_next = timeouts_reg + CNT_W'(1);
            if (miss_reg < MISS_SAT)
                miss_next = miss_reg + 3'd1;
            if (miss_next >= MISS_LIMIT)
            begin
                valid_next  = 1'b0;
                streak_next = '0;
            end
        end
        else
        begin
            miss_next             = '0;
            window_next[pos_reg]  = distance;
            pos_next              = (pos_reg == WIN_LAST) ? 2'd0 : pos_reg + 2'd1;
            if (fill_reg < WIN_FULL)
                fill_next = fill_reg + 2'd1;
            // Use the raw distance until the window holds three readings
            last_next = (fill_next < WIN_FULL) ? distance
                      : median3(window_next[0], window_next[1], window_next[2]);
            valid_next = 1'b1;

            if (!close_reg)
            begin
                if (last_next < cfg.close_threshold)
                begin
                    streak_next = streak_inc;
                    if (streak_inc >= cfg.debounce_count)
                    begin
                        close_next  = 1'b1;
                        streak_next = '0;
                        ev          = EV_CLOSE;
                    end
                end
                else
                begin
                    streak_next = '0;
                end
            end
            else if (last_next > cfg.clear_threshold)
            begin
                close_next = 1'b0;
                ev         = EV_CLEAR;
            end
        end
    end

    assign res.reading_valid     = valid_next;
    assign res.filtered_distance = last_next;
    assign res.event_kind        = ev;
    assign res.timeout_count     = timeouts_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg[0] <= '0;
            window_reg[1] <= '0;
            window_reg[2] <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            miss_reg      <= '0;
            valid_reg     <= 1'b0;
            close_reg     <= 1'b0;
            streak_reg    <= '0;
            timeouts_reg  <= '0;
            last_reg      <= '0;
        end
        else if (advance)
        begin
            window_reg    <= window_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            miss_reg      <= miss_next;
            valid_reg     <= valid_next;
            close_reg     <= close_next;
            streak_reg    <= streak_next;
            timeouts_reg  <= timeouts_next;
            last_reg      <= last_next;
        end
    end

endmodule

// ===== sv/ultrasonic_range_qualifier.sv =====
// Ultrasonic range qualifier top level: input register, tracking logic, result register.
// Takes one echo time per cycle and returns one result per echo. An echo is captured in
// the input register on its transfer, all arithmetic (reciprocal multiply for the
// distance, three-entry median, threshold compares) is combinational between the input
// register and the result register, which takes the result when the input register
// advances, so a new echo can be taken every cycle. Only a held result register stalls
// the input. Configuration through the APB port takes effect
// for the next echo processed.
module ultrasonic_range_qualifier (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  echo_valid,
    output logic                  echo_ready,
    input  logic [15:0]           echo_time,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  reading_valid,
    output logic [14:0]           filtered_distance,
    output urq_pkg::event_kind_t  event_kind,
    output logic [15:0]           timeout_count
);
    import urq_pkg::*;

    cfg_t              cfg;
    result_t           res;
    result_t           res_reg;
    logic              in_valid_reg, in_valid_next;
    logic [ECHO_W-1:0] echo_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] distance;
    logic              advance;
    logic              take;

    urq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    urq_dist u_dist (
        .echo_time (echo_reg),
        .distance  (distance)
    );

    urq_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .echo_time (echo_reg),
        .distance  (distance),
        .cfg       (cfg),
        .res       (res)
    );

    // Advance when the result register is empty or being drained
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign echo_ready = !in_valid_reg || advance;
    assign take       = echo_valid && echo_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            echo_reg <= echo_time;
        if (advance)
            res_reg <= res;
    end

    assign result_valid      = out_valid_reg;
    assign reading_valid     = res_reg.reading_valid;
    assign filtered_distance = res_reg.filtered_distance;
    assign event_kind        = res_reg.event_kind;
    assign timeout_count     = res_reg.timeout_count;

endmodule

// ===== sv/urq_checker.sv =====
// Port-level checks of the ultrasonic range qualifier, bound to the top level.
module urq_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  echo_ready,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic                  reading_valid,
    input  logic [14:0]           filtered_distance,
    input  urq_pkg::event_kind_t  event_kind,
    input  logic [15:0]           timeout_count
);
    import urq_pkg::*;

    logic [CNT_W-1:0] last_to_reg, last_to_next;

    assign last_to_next = (result_valid && result_ready) ? timeout_count : last_to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_to_reg <= '0;
        else
            last_to_reg <= last_to_next;
    end

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(filtered_distance) && $stable(timeout_count))
        else $error("stalled result changed");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !echo_ready |-> result_valid && !result_ready)
        else $error("input stalled without a held result");

    a_event_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind != EV_NONE |-> reading_valid)
        else $error("event on an untrusted reading");

    a_timeout_mono: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> timeout_count >= last_to_reg)
        else $error("timeout count went down");

endmodule

bind ultrasonic_range_qualifier urq_checker u_urq_checker (.*);

// ===== test/range_result_checker.sv =====
// Checker for the range qualifier: tracks echo transfers, predicts each result and compares.
module range_result_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 echo_valid,
    input  logic                 echo_ready,
    input  logic [15:0]          echo_time,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  logic                 reading_valid,
    input  logic [14:0]          filtered_distance,
    input  urq_pkg::event_kind_t event_kind,
    input  logic [15:0]          timeout_count,
    output int                   errors,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import urq_pkg::*;

    cfg_t              settings;
    logic [DIST_W-1:0] recent [0:2];
    logic [1:0]        slot;
    logic [1:0]        filled;
    logic [2:0]        misses;
    logic              trusted;
    logic              near;
    logic [3:0]        near_run;
    logic [CNT_W-1:0]  no_echo_count;
    logic [DIST_W-1:0] held_distance;

    result_t expected_readings [$];
    result_t want;
    result_t fresh;

    function automatic logic [DIST_W-1:0] middle_distance(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b,
        input logic [DIST_W-1:0] c
    );
        if ((a >= b && a <= c) || (a <= b && a >= c))
            return a;
        if ((b >= a && b <= c) || (b <= a && b >= c))
            return b;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        errors++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
    endtask

    // Advance the tracking state by one echo and form the reading it produces.
    task automatic track_echo(input logic [ECHO_W-1:0] echo, output result_t r);
        logic [31:0]       scaled;
        logic [DIST_W-1:0] echo_range;
        event_kind_t       ev;
        ev = EV_NONE;
        if (echo == '0 || echo > settings.max_echo_us) begin
            if (echo == '0 && no_echo_count != '1)
                no_echo_count++;
            if (misses != MISS_SAT)
                misses++;
            if (misses >= MISS_LIMIT) begin
                trusted  = 1'b0;
                near_run = '0;
            end
        end else begin
            scaled     = ({16'd0, echo} * 32'd8) / 32'd29;
            echo_range = scaled[DIST_W-1:0];
            misses = '0;
            recent[slot] = echo_range;
            slot = (slot == WIN_LAST) ? 2'd0 : slot + 2'd1;
            if (filled != WIN_FULL)
                filled++;
            held_distance = (filled != WIN_FULL) ? echo_range
                          : middle_distance(recent[0], recent[1], recent[2]);
            trusted = 1'b1;
            if (!near) begin
                if (held_distance < settings.close_threshold) begin
                    if (near_run != STREAK_SAT)
                        near_run++;
                    if (near_run >= settings.debounce_count) begin
                        near     = 1'b1;
                        near_run = '0;
                        ev       = EV_CLOSE;
                    end
                end else begin
                    near_run = '0;
                end
            end else if (held_distance > settings.clear_threshold) begin
                near = 1'b0;
                ev   = EV_CLEAR;
            end
        end
        r.reading_valid     = trusted;
        r.filtered_distance = held_distance;
        r.event_kind        = ev;
        r.timeout_count     = no_echo_count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            settings.max_echo_us     = ECHO_MAX_RESET;
            settings.close_threshold = CLOSE_TH_RESET;
            settings.clear_threshold = CLEAR_TH_RESET;
            settings.debounce_count  = DEBOUNCE_RESET;
            recent[0]     = '0;
            recent[1]     = '0;
            recent[2]     = '0;
            slot          = '0;
            filled        = '0;
            misses        = '0;
            trusted       = 1'b0;
            near          = 1'b0;
            near_run      = '0;
            no_echo_count = '0;
            held_distance = '0;
            expected_readings.delete();
            errors        = 0;
            outstanding  <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MAX_ECHO: settings.max_echo_us     = pwdata[ECHO_W-1:0];
                    REG_CLOSE_TH: settings.close_threshold = pwdata[DIST_W-1:0];
                    REG_CLEAR_TH: settings.clear_threshold = pwdata[DIST_W-1:0];
                    REG_DEBOUNCE: settings.debounce_count  = pwdata[3:0];
                    default: ;
                endcase
            end
            if (result_valid && result_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with none expected, distance",
                                    filtered_distance, -1);
                end else begin
                    want = expected_readings.pop_front();
                    if (reading_valid !== want.reading_valid)
                        report_mismatch("reading_valid", reading_valid, want.reading_valid);
                    if (filtered_distance !== want.filtered_distance)
                        report_mismatch("filtered_distance", filtered_distance,
                                        want.filtered_distance);
                    if (event_kind !== want.event_kind)
                        report_mismatch("event_kind", event_kind, want.event_kind);
                    if (timeout_count !== want.timeout_count)
                        report_mismatch("timeout_count", timeout_count, want.timeout_count);
                end
            end
            if (echo_valid && echo_ready) begin
                track_echo(echo_time, fresh);
                expected_readings.push_back(fresh);
            end
            outstanding <= expected_readings.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the range qualifier testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import urq_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_ITEMS = 180;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        echo_valid   = 1'b0;
    logic        echo_ready;
    logic [15:0] echo_time    = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        reading_valid;
    logic [14:0] filtered_distance;
    event_kind_t event_kind;
    logic [15:0] timeout_count;

    int fail_count;
    int pending_results;
    bit calm        = 1'b0;
    int rx_hold     = 0;
    int idle_cycles = 0;

    logic [ECHO_W-1:0] cur_max_echo = ECHO_MAX_RESET;
    logic [DIST_W-1:0] cur_close    = CLOSE_TH_RESET;
    logic [DIST_W-1:0] cur_clear    = CLEAR_TH_RESET;

    always #2 clk = ~clk;

    ultrasonic_range_qualifier i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .echo_valid        (echo_valid),
        .echo_ready        (echo_ready),
        .echo_time         (echo_time),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .reading_valid     (reading_valid),
        .filtered_distance (filtered_distance),
        .event_kind        (event_kind),
        .timeout_count     (timeout_count)
    );

    range_result_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .echo_valid        (echo_valid),
        .echo_ready        (echo_ready),
        .echo_time         (echo_time),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .reading_valid     (reading_valid),
        .filtered_distance (filtered_distance),
        .event_kind        (event_kind),
        .timeout_count     (timeout_count),
        .errors            (fail_count),
        .outstanding       (pending_results)
    );

    // Mostly short gaps, now and then a long one, none while calm.
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [ECHO_W-1:0] miss_echo();
        if (cur_max_echo == '1 || $urandom_range(0, 1) == 0)
            return '0;
        return 16'($urandom_range(int'(cur_max_echo) + 1, 65535));
    endfunction

    always @(posedge clk)
    begin
        if (rx_hold != 0) begin
            rx_hold      <= rx_hold - 1;
            result_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            rx_hold      <= stall_len();
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((echo_valid && echo_ready) || (result_valid && result_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Keep valid high across back-to-back transfers; drop it only for a gap.
    task automatic send_echo(input logic [ECHO_W-1:0] e);
        int gap;
        gap = stall_len();
        if (gap != 0) begin
            echo_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        echo_valid <= 1'b1;
        echo_time  <= e;
        do
            @(posedge clk);
        while (!echo_ready);
    endtask

    // Hold the sender until every expected reading has come back.
    task automatic drain();
        echo_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic set_config(
        input logic [ECHO_W-1:0] max_echo,
        input logic [DIST_W-1:0] close_th,
        input logic [DIST_W-1:0] clear_th,
        input logic [3:0]        debounce
    );
        drain();
        write_reg(REG_MAX_ECHO, 32'(max_echo));
        write_reg(REG_CLOSE_TH, 32'(close_th));
        write_reg(REG_CLEAR_TH, 32'(clear_th));
        write_reg(REG_DEBOUNCE, 32'(debounce));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_max_echo = max_echo;
        cur_close    = close_th;
        cur_clear    = clear_th;
    endtask

    task automatic send_burst(output int n);
        int               kind;
        int               len;
        int               target;
        int               e;
        logic [ECHO_W-1:0] v;
        kind = $urandom_range(0, 9);
        calm = ($urandom_range(0, 5) == 0);
        n    = 0;
        if (kind <= 4) begin
            // walk the distance around the two thresholds to provoke events
            len    = $urandom_range(4, 24);
            target = int'(cur_close);
            for (int i = 0; i < len; i++) begin
                if (i == 0 || $urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    target = int'(cur_close);
                        2, 3:    target = int'(cur_clear);
                        default: target = $urandom_range(0, 18078);
                    endcase
                end
                e = target * 29 / 8 + int'($urandom_range(0, 160)) - 80;
                if (e < 1)
                    e = 1;
                if (e > 65535)
                    e = 65535;
                if ($urandom_range(0, 9) == 0)
                    send_echo(miss_echo());
                else
                    send_echo(16'(e));
                n++;
            end
        end else if (kind <= 6) begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                send_echo(miss_echo());
                n++;
            end
        end else if (kind == 7) begin
            len = $urandom_range(1, 10);
            repeat (len)
            begin
                send_echo(16'($urandom));
                n++;
            end
        end else if (kind == 8) begin
            v = cur_max_echo;
            send_echo(v);
            send_echo(v + 16'd1);
            send_echo(v - 16'd1);
            n += 3;
        end else begin
            len = $urandom_range(1, 6);
            repeat (len)
            begin
                send_echo(16'($urandom_range(1, 60)));
                n++;
            end
        end
    endtask

    initial
    begin
        logic [ECHO_W-1:0] opening [0:21];
        int                n;
        int                sent;
        int                budget;
        opening = '{16'd0, 16'hFFFF, 16'd30000, 16'd30001, 16'd1, 16'd29,
                    16'd1000, 16'd1100, 16'd1200, 16'd1150, 16'd5000, 16'd5200,
                    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                    16'h5555, 16'h2AAA, 16'd1740, 16'd1741};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_echo(opening[i]);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(16'hFFFF, 15'd0, 15'd0, 4'd15);
                1: set_config(16'd0, CLOSE_TH_RESET, CLEAR_TH_RESET, 4'd1);
                2: set_config(16'hFFFF, 15'd18078, 15'd18078, 4'd0);
                3: set_config(16'd32767, 15'h7FFF, 15'd0, 4'd2);
                default: set_config(16'($urandom_range(2000, 65535)),
                                    15'($urandom_range(0, 3000)),
                                    15'($urandom_range(0, 3500)),
                                    4'($urandom_range(0, 15)));
            endcase
            budget = (p == 1) ? 60 : PHASE_ITEMS;
            sent   = 0;
            while (sent < budget) begin
                send_burst(n);
                sent += n;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
